>>> rtl/core/utep_pkg.sv
// ----------------------------------------------------------------------------
// utep_pkg: shared types for the UTC timestamp to epoch parser
// Beat structs, the date record that the parser front hands to the
// conversion back, and the state type of the back sequencer.
// ----------------------------------------------------------------------------
package utep_pkg;

  // One input beat: a character of the timestamp text and its end flag.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic        valid_res;
    logic [37:0] epoch_seconds;
  } out_beat_t;

  // A two-digit decimal field (0..99).
  typedef logic [6:0] field_t;

  // A parsed timestamp, the year split into its upper and lower digit pairs.
  typedef struct packed {
    logic   ok;
    field_t year_hi;
    field_t year_lo;
    field_t month;
    field_t day;
    field_t hour;
    field_t minute;
    field_t second;
  } date_rec_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DAYS,
    BK_SECS
  } back_state_e;

endpackage

>>> rtl/core/utep_front.sv
// ----------------------------------------------------------------------------
// utep_front: character parser
// Takes one character per beat, checks separators and digits, accumulates
// the decimal fields and, on the final character, checks ranges and emits
// a date record.
// ----------------------------------------------------------------------------
module utep_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  utep_pkg::in_beat_t  beat_i,
  output logic                push_o,
  output utep_pkg::date_rec_t rec_o
);
  import utep_pkg::*;

  localparam logic [4:0] TsLen      = 5'd20;
  localparam logic [4:0] PosYearLo  = 5'd2;
  localparam logic [4:0] PosDashA   = 5'd4;
  localparam logic [4:0] PosDashB   = 5'd7;
  localparam logic [4:0] PosT       = 5'd10;
  localparam logic [4:0] PosColonA  = 5'd13;
  localparam logic [4:0] PosColonB  = 5'd16;
  localparam logic [4:0] PosZ       = 5'd19;

  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZ     = 8'h5A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  function automatic field_t dec_step(input field_t acc, input logic [3:0] dv);
    logic [10:0] t;
    t = 11'(acc) * 11'd10 + 11'(dv);
    return t[6:0];
  endfunction

  function automatic field_t month_len(input field_t m, input logic leap);
    field_t n;
    unique case (m)
      7'd2:                      n = leap ? 7'd29 : 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   n = 7'd30;
      default:                   n = 7'd31;
    endcase
    return n;
  endfunction

  logic [4:0] pos_q, pos_d;
  logic       bad_q, bad_d;
  field_t     hi_q, hi_d, lo_q, lo_d, mon_q, mon_d, day_q, day_d;
  field_t     hour_q, hour_d, min_q, min_d, sec_q, sec_d;

  logic       is_digit;
  logic [3:0] dv;
  logic       leap;
  logic       year_ok;
  logic       ok;

  assign is_digit = (beat_i.char_byte >= ChZero) && (beat_i.char_byte <= ChNine);
  assign dv       = 4'(beat_i.char_byte - ChZero);

  // Range checks look at the fields as they stand after this character.
  assign leap    = (lo_d[1:0] == 2'd0) && ((lo_d != 7'd0) || (hi_d[1:0] == 2'd0));
  assign year_ok = (hi_d > 7'd19) || ((hi_d == 7'd19) && (lo_d >= 7'd70));
  assign ok      = !bad_d && (pos_d == TsLen) && year_ok
                   && (mon_d >= 7'd1) && (mon_d <= 7'd12)
                   && (day_d >= 7'd1) && (day_d <= month_len(mon_d, leap))
                   && (hour_d <= 7'd23) && (min_d <= 7'd59) && (sec_d <= 7'd59);

  always_comb begin
    pos_d  = pos_q;
    bad_d  = bad_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    mon_d  = mon_q;
    day_d  = day_q;
    hour_d = hour_q;
    min_d  = min_q;
    sec_d  = sec_q;
    if (take_i) begin
      if (pos_q >= TsLen) begin
        // Too long: the position stays saturated and the string is bad.
        bad_d = 1'b1;
      end else begin
        unique case (pos_q)
          PosDashA, PosDashB: begin
            if (beat_i.char_byte != ChDash) bad_d = 1'b1;
          end
          PosT: begin
            if (beat_i.char_byte != ChT) bad_d = 1'b1;
          end
          PosColonA, PosColonB: begin
            if (beat_i.char_byte != ChColon) bad_d = 1'b1;
          end
          PosZ: begin
            if (beat_i.char_byte != ChZ) bad_d = 1'b1;
          end
          default: begin
            if (!is_digit)             bad_d  = 1'b1;
            else if (pos_q < PosYearLo) hi_d   = dec_step(hi_q, dv);
            else if (pos_q < PosDashA)  lo_d   = dec_step(lo_q, dv);
            else if (pos_q < PosDashB)  mon_d  = dec_step(mon_q, dv);
            else if (pos_q < PosT)      day_d  = dec_step(day_q, dv);
            else if (pos_q < PosColonA) hour_d = dec_step(hour_q, dv);
            else if (pos_q < PosColonB) min_d  = dec_step(min_q, dv);
            else                        sec_d  = dec_step(sec_q, dv);
          end
        endcase
        pos_d = pos_q + 5'd1;
      end
    end
  end

  assign push_o        = take_i && beat_i.last_char;
  assign rec_o.ok      = ok;
  assign rec_o.year_hi = hi_d;
  assign rec_o.year_lo = lo_d;
  assign rec_o.month   = mon_d;
  assign rec_o.day     = day_d;
  assign rec_o.hour    = hour_d;
  assign rec_o.minute  = min_d;
  assign rec_o.second  = sec_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      bad_q  <= 1'b0;
      hi_q   <= '0;
      lo_q   <= '0;
      mon_q  <= '0;
      day_q  <= '0;
      hour_q <= '0;
      min_q  <= '0;
      sec_q  <= '0;
    end else if (push_o) begin
      pos_q  <= '0;
      bad_q  <= 1'b0;
      hi_q   <= '0;
      lo_q   <= '0;
      mon_q  <= '0;
      day_q  <= '0;
      hour_q <= '0;
      min_q  <= '0;
      sec_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      bad_q  <= bad_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      mon_q  <= mon_d;
      day_q  <= day_d;
      hour_q <= hour_d;
      min_q  <= min_d;
      sec_q  <= sec_d;
    end
  end

endmodule

>>> rtl/core/utep_queue.sv
// ----------------------------------------------------------------------------
// utep_queue: two-entry date record queue
// Decouples the character parser from the epoch conversion.
// ----------------------------------------------------------------------------
module utep_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  utep_pkg::date_rec_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output utep_pkg::date_rec_t head_o
);
  import utep_pkg::*;

  date_rec_t  entries_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/core/utep_back.sv
// ----------------------------------------------------------------------------
// utep_back: epoch conversion
// Three-step sequencer: year and day-of-year terms, day count, seconds.
// Holds the result in an output register until the consumer takes it.
// ----------------------------------------------------------------------------
module utep_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  utep_pkg::date_rec_t  head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output utep_pkg::out_beat_t  out_beat_o
);
  import utep_pkg::*;

  // Days before the first of each month, counting from March.
  function automatic logic [8:0] march_days(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  back_state_e state_q, state_d;
  logic        load_out;

  // Step one results.
  logic        ok_q;
  logic [13:0] yval_q;
  logic [11:0] corr_q;
  logic [8:0]  ydays_q;
  field_t      hour_q, min_q, sec_q;
  // Step two results.
  logic [21:0] days_q;
  logic [16:0] hms_q;

  logic        out_valid_q;
  out_beat_t   out_beat_q;

  // Step one: shift the year so that it starts in March.
  logic        early;
  field_t      hi_y, lo_y;
  logic [3:0]  mp;
  logic [13:0] yval_d;
  logic [11:0] corr_d;
  logic [8:0]  ydays_d;

  always_comb begin
    early = (head_i.month <= 7'd2);
    hi_y  = head_i.year_hi;
    lo_y  = head_i.year_lo;
    if (early) begin
      if (head_i.year_lo == 7'd0) begin
        hi_y = head_i.year_hi - 7'd1;
        lo_y = 7'd99;
      end else begin
        lo_y = head_i.year_lo - 7'd1;
      end
    end
    mp      = early ? 4'(head_i.month + 7'd9) : 4'(head_i.month - 7'd3);
    yval_d  = 14'(hi_y) * 14'd100 + 14'(lo_y);
    // Y/4 - Y/100 + Y/400 written with Y = 100*hi + lo.
    corr_d  = 12'(hi_y) * 12'd24 + 12'(hi_y >> 2) + 12'(lo_y >> 2);
    ydays_d = march_days(mp) + 9'(head_i.day) - 9'd1;
  end

  // Step two: day count from the epoch and seconds within the day.
  logic [22:0] days_full;
  logic [16:0] hms_d;
  assign days_full = 23'(yval_q) * 23'd365 + 23'(corr_q) + 23'(ydays_q) - 23'd719468;
  assign hms_d     = 17'(hour_q) * 17'd3600 + 17'(min_q) * 17'd60 + 17'(sec_q);

  // Step three: seconds.
  logic [37:0] secs;
  assign secs = 38'(days_q) * 38'd86400 + 38'(hms_q);

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_DAYS;
        end
      end
      BK_DAYS: begin
        state_d = BK_SECS;
      end
      BK_SECS: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q    <= head_i.ok;
      yval_q  <= yval_d;
      corr_q  <= corr_d;
      ydays_q <= ydays_d;
      hour_q  <= head_i.hour;
      min_q   <= head_i.minute;
      sec_q   <= head_i.second;
    end
    if (state_q == BK_DAYS) begin
      days_q <= days_full[21:0];
      hms_q  <= hms_d;
    end
    if (load_out) begin
      out_beat_q.valid_res     <= ok_q;
      out_beat_q.epoch_seconds <= ok_q ? secs : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

>>> rtl/core/utc_timestamp_to_epoch_parser.sv
// ----------------------------------------------------------------------------
// utc_timestamp_to_epoch_parser: ISO 8601 UTC timestamp to Unix seconds
// Parses YYYY-MM-DDTHH:MM:SSZ one character per beat and returns a valid
// flag and the seconds since 1970-01-01T00:00:00Z for each string.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Beat
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o | char_byte, last_char
//   out     | output    | out_valid_o / out_stall_i | valid_res, epoch_seconds
//
// The parser front takes one character per cycle while the queue has room. A beat with last_char set
// closes the string: its checked fields go as one record into a two-entry
// queue, and the front starts on the next string in the following cycle.
// The conversion back takes each record through year terms, day count and
// seconds multiply, registering each, and then loads the output register;
// only then does it go back to idle and take the next record.
// Reset is asynchronous and clears all control and accumulator state.
// in_stall_o rises while the queue holds two records; the output register
// holds its beat while out_stall_i is high and the back waits in its last
// step.
module utc_timestamp_to_epoch_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  utep_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output utep_pkg::out_beat_t out_beat_o
);
  import utep_pkg::*;

  logic      take;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  date_rec_t q_in;
  date_rec_t q_head;

  // The front may only run while the queue has room for a closing record.
  assign in_stall_o = q_full;
  assign take       = in_valid_i && !in_stall_o;

  utep_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .beat_i (in_beat_i),
    .push_o (q_push),
    .rec_o  (q_in)
  );

  utep_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  utep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  // A record is never pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("record pushed into full queue");

  // The back only takes a record that is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("record popped from empty queue");

  // An invalid result always carries zero seconds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_beat_o.valid_res) |-> (out_beat_o.epoch_seconds == '0))
    else $error("invalid result with nonzero seconds");

endmodule

>>> dv/utc_timestamp_to_epoch_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utc_timestamp_to_epoch_parser_test: self-checking bench for the parser
// Streams timestamp text one character per beat through the in channel,
// predicts each string's validity and epoch seconds, and checks every beat
// of the out channel in order against those predictions.
// ----------------------------------------------------------------------------
module utc_timestamp_to_epoch_parser_test;
  import utep_pkg::*;

  // Number of characters that the random part of the stimulus feeds.
  localparam int unsigned RANDOM_CHARS = 1200;
  // Hard stop. The slowest correct run (every beat after its longest gap and
  // every result behind its longest stall) stays far below this.
  localparam int unsigned CYCLE_LIMIT  = 600000;
  // Cycles that the bench lets pass after the last expected result.
  localparam int unsigned TAIL_CYCLES  = 24;
  // Fault position meaning that every character is kept as written in the timestamp text.
  localparam int          NO_FAULT     = -1;
  localparam int unsigned STAMP_LEN    = 20;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  // One character waiting to be sent, with the idle cycles that go before
  // it and a flag that holds it back until every expected result has come.
  typedef struct packed {
    in_beat_t    beat;
    logic [3:0]  idle;
    logic        drain;
  } feed_item_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  feed_item_t  char_feed_q[$];
  out_beat_t   epoch_results_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Burst modes: while set, that side of the bench draws no idle gaps or stalls.
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  // Driver bookkeeping.
  int unsigned idle_left = 0;
  bit          idle_loaded = 1'b0;
  // Monitor bookkeeping.
  int unsigned stall_left = 0;

  // Shadow of the parser's string state.
  logic [4:0]  ts_pos = '0;
  logic        ts_bad = 1'b0;
  logic [13:0] ts_year = '0;
  logic [6:0]  ts_month = '0;
  logic [6:0]  ts_day = '0;
  logic [6:0]  ts_hour = '0;
  logic [6:0]  ts_minute = '0;
  logic [6:0]  ts_second = '0;

  utc_timestamp_to_epoch_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  always #2 clk_i = ~clk_i;

  // Gregorian month lengths, February following the leap year rule.
  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    bit leap_year;
    leap_year = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      2: begin
        return leap_year ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // Days from 1970-01-01 to the given date. The year is shifted so that it
  // starts in March, which puts the leap day at the end of the counted year;
  // eras of 400 years repeat exactly every 146097 days.
  function automatic longint unsigned days_since_epoch(int unsigned y, int unsigned m,
                                                       int unsigned d);
    longint unsigned yy, era, yoe, mp, doy, doe;
    yy  = y;
    if (m <= 2) yy = yy - 1;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  // Takes one accepted character into the shadow state. A final character
  // closes the string: its verdict and seconds join the expected results and
  // the shadow state clears, whatever the verdict.
  task automatic take_timestamp_char(in_beat_t b);
    logic [7:0]      c;
    bit              digit;
    logic [3:0]      dv;
    bit              ok;
    longint unsigned secs;
    out_beat_t       res;
    c     = b.char_byte;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    dv    = digit ? 4'(c - CH_ZERO) : 4'd0;
    if (ts_pos >= STAMP_LEN) begin
      // Characters past the closing Z spoil the string; the count saturates.
      ts_bad = 1'b1;
    end else begin
      case (ts_pos)
        5'd4, 5'd7: begin
          if (c != CH_DASH) ts_bad = 1'b1;
        end
        5'd10: begin
          if (c != CH_T) ts_bad = 1'b1;
        end
        5'd13, 5'd16: begin
          if (c != CH_COLON) ts_bad = 1'b1;
        end
        5'd19: begin
          if (c != CH_Z) ts_bad = 1'b1;
        end
        default: begin
          if (!digit) begin
            ts_bad = 1'b1;
          end else if (ts_pos < 4) begin
            ts_year = 14'(ts_year * 10 + dv);
          end else if (ts_pos < 7) begin
            ts_month = 7'(ts_month * 10 + dv);
          end else if (ts_pos < 10) begin
            ts_day = 7'(ts_day * 10 + dv);
          end else if (ts_pos < 13) begin
            ts_hour = 7'(ts_hour * 10 + dv);
          end else if (ts_pos < 16) begin
            ts_minute = 7'(ts_minute * 10 + dv);
          end else begin
            ts_second = 7'(ts_second * 10 + dv);
          end
        end
      endcase
      ts_pos = ts_pos + 5'd1;
    end
    if (b.last_char) begin
      // A string that ends early or carries any fault yields zero seconds.
      ok = !ts_bad && (ts_pos == STAMP_LEN) && (ts_year >= 1970)
           && (ts_month >= 1) && (ts_month <= 12)
           && (ts_day >= 1) && (ts_day <= days_in_month(ts_year, ts_month))
           && (ts_hour <= 23) && (ts_minute <= 59) && (ts_second <= 59);
      secs = 0;
      if (ok) begin
        secs = days_since_epoch(ts_year, ts_month, ts_day) * 86400
               + longint'(ts_hour) * 3600 + longint'(ts_minute) * 60
               + longint'(ts_second);
      end
      res.valid_res     = ok;
      res.epoch_seconds = secs[37:0];
      epoch_results_q.push_back(res);
      ts_pos    = '0;
      ts_bad    = 1'b0;
      ts_year   = '0;
      ts_month  = '0;
      ts_day    = '0;
      ts_hour   = '0;
      ts_minute = '0;
      ts_second = '0;
    end
  endtask

  // Compares one result beat with the oldest prediction, field by field.
  task automatic check_epoch_result(out_beat_t got);
    out_beat_t want;
    if (epoch_results_q.size() == 0) begin
      $display("%0t: result with nothing expected: valid_res %0b epoch_seconds %0d",
               $time, got.valid_res, got.epoch_seconds);
      error_count++;
    end else begin
      want = epoch_results_q.pop_front();
      if (got.valid_res !== want.valid_res) begin
        $display("%0t: valid_res expected %0b actual %0b",
                 $time, want.valid_res, got.valid_res);
        error_count++;
      end
      if (got.epoch_seconds !== want.epoch_seconds) begin
        $display("%0t: epoch_seconds expected %0d actual %0d",
                 $time, want.epoch_seconds, got.epoch_seconds);
        error_count++;
      end
    end
  endtask

  // Queues one character. The sender's gap before it is drawn here; now and
  // then the sender switches between gapped and back-to-back stretches.
  task automatic queue_char(logic [7:0] c, logic last, logic drain);
    feed_item_t item;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    item.beat.char_byte = c;
    item.beat.last_char = last;
    item.idle  = send_burst ? 4'd0 : 4'($urandom_range(0, 14));
    item.drain = drain;
    char_feed_q.push_back(item);
  endtask

  // Queues the first len characters of a timestamp. Characters past the
  // twentieth are random, and the one at bad_pos, if any, is replaced by a
  // random byte. Only the last character carries the end flag.
  task automatic queue_stamp(string text, int unsigned len, int bad_pos, logic drain);
    logic [7:0] c;
    for (int unsigned i = 0; i < len; i++) begin
      c = (i < STAMP_LEN) ? text[i] : 8'($urandom_range(0, 255));
      if (int'(i) == bad_pos) c = 8'($urandom_range(0, 255));
      queue_char(c, i == len - 1, drain && (i == 0));
    end
  endtask

  function automatic string stamp_text(int unsigned y, int unsigned mo, int unsigned d,
                                       int unsigned h, int unsigned mi, int unsigned s);
    return $sformatf("%04d-%02d-%02dT%02d:%02d:%02dZ", y, mo, d, h, mi, s);
  endfunction

  // A calendar-correct timestamp, biased toward the ends of every field but the month.
  function automatic string random_good_stamp();
    int unsigned y, mo, d, h, mi, s;
    case ($urandom_range(0, 7))
      0: y = 1970;
      1: y = 9999;
      2: y = 4 * $urandom_range(493, 2499);
      default: y = $urandom_range(1970, 9999);
    endcase
    mo = $urandom_range(1, 12);
    d  = ($urandom_range(0, 3) == 0) ? days_in_month(y, mo)
                                     : $urandom_range(1, days_in_month(y, mo));
    h  = ($urandom_range(0, 5) == 0) ? 23 : $urandom_range(0, 23);
    mi = ($urandom_range(0, 5) == 0) ? 59 : $urandom_range(0, 59);
    s  = ($urandom_range(0, 5) == 0) ? 59 : $urandom_range(0, 59);
    return stamp_text(y, mo, d, h, mi, s);
  endfunction

  // Driver. A stalled beat holds; otherwise the head of the feed goes out
  // once its gap has passed, and a beat marked to drain waits until no
  // result is outstanding. Valid and payload change once per edge at most.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      in_beat     <= '0;
      idle_left   = 0;
      idle_loaded = 1'b0;
    end else begin
      if (in_valid && !in_stall) take_timestamp_char(in_beat);
      if (!(in_valid && in_stall)) begin
        if (char_feed_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          if (!idle_loaded) begin
            idle_left   = char_feed_q[0].idle;
            idle_loaded = 1'b1;
          end
          if (idle_left != 0) begin
            idle_left--;
            in_valid <= 1'b0;
          end else if (char_feed_q[0].drain && epoch_results_q.size() != 0) begin
            in_valid <= 1'b0;
          end else begin
            in_valid    <= 1'b1;
            in_beat     <= char_feed_q[0].beat;
            idle_loaded = 1'b0;
            void'(char_feed_q.pop_front());
          end
        end
      end
    end
  end

  // Monitor. Each accepted result is checked, then the receiver draws how
  // long it stalls the next one; the count runs down only while a result
  // is offered, so every drawn stall is spent on a waiting beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_epoch_result(out_beat);
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 14);
      end else if (out_valid && stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    int unsigned directed_chars;
    int unsigned kind;
    logic        drain;
    string       text;

    // Directed strings: the epoch itself, the largest date, leap days in
    // and out of leap years, every field one past its range, wrong
    // separators, a letter among the digits, and strings too short and
    // too long.
    queue_stamp("1970-01-01T00:00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("9999-12-31T23:59:59Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2000-02-29T12:34:56Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2024-02-29T23:59:59Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2100-02-29T00:00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2023-02-29T00:00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("1969-12-31T23:59:59Z", 20, NO_FAULT, 1'b0);
    queue_stamp("0000-00-00T00:00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2038-01-19T03:14:08Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2021-13-01T00:00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2021-04-31T00:00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2021-04-00T00:00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2021-05-05T24:00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2021-05-05T23:60:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2021-05-05T23:59:60Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2021-05-05 10:00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2021/05-05T10:00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2021-05-05T10.00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2021-05-05T10:00:00z", 20, NO_FAULT, 1'b0);
    queue_stamp("2O21-05-05T10:00:00Z", 20, NO_FAULT, 1'b0);
    queue_stamp("2021-05-05T10:00:00Z", 19, NO_FAULT, 1'b0);
    queue_stamp("2021-05-05T10:00:00Z", 1, NO_FAULT, 1'b0);
    queue_stamp("2021-05-05T10:00:00Z", 22, NO_FAULT, 1'b0);
    directed_chars = char_feed_q.size();

    // Random part: mostly well-formed strings, then strings with fields out
    // of range, a corrupted character, a missing tail or extra characters,
    // and raw byte noise. Now and then a string waits for the output side
    // to drain completely before its first character goes out.
    while (char_feed_q.size() - directed_chars < RANDOM_CHARS) begin
      kind  = $urandom_range(0, 99);
      drain = ($urandom_range(0, 24) == 0) || (char_feed_q.size() == directed_chars);
      text  = random_good_stamp();
      if (kind < 60) begin
        queue_stamp(text, STAMP_LEN, NO_FAULT, drain);
      end else if (kind < 75) begin
        text = stamp_text($urandom_range(0, 9999), $urandom_range(0, 99),
                          $urandom_range(0, 99), $urandom_range(0, 99),
                          $urandom_range(0, 99), $urandom_range(0, 99));
        queue_stamp(text, STAMP_LEN, NO_FAULT, drain);
      end else if (kind < 85) begin
        queue_stamp(text, STAMP_LEN, $urandom_range(0, STAMP_LEN - 1), drain);
      end else if (kind < 90) begin
        queue_stamp(text, $urandom_range(1, STAMP_LEN - 1), NO_FAULT, drain);
      end else if (kind < 95) begin
        queue_stamp(text, $urandom_range(STAMP_LEN + 1, STAMP_LEN + 4), NO_FAULT, drain);
      end else begin
        for (int unsigned i = 0, n = $urandom_range(1, 25); i < n; i++) begin
          queue_char(8'($urandom_range(0, 255)), i == n - 1, drain && (i == 0));
        end
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the feed to empty and every predicted result to arrive, then
    // give the block time to show any stray beat.
    while (char_feed_q.size() != 0 || in_valid || epoch_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("utc_timestamp_to_epoch_parser test passed");
    end else begin
      $display("utc_timestamp_to_epoch_parser test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("utc_timestamp_to_epoch_parser test failed");
    $finish;
  end

endmodule
